[hw/rtl/gated_ema_step_macros.svh]
// ----------------------------------------------------------------------------
// gated ema step assertion macros
// Shared property forms used by the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GATED_EMA_STEP_MACROS_SVH
`define GATED_EMA_STEP_MACROS_SVH

// same-cycle implication
`define GEMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gated_ema_step: same-cycle check failed");

// next-cycle implication
`define GEMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gated_ema_step: next-cycle check failed");

`endif

[hw/rtl/gema_pkg.sv]
// ----------------------------------------------------------------------------
// gema_pkg
// Shared constants, types and arithmetic helpers of the gated ema step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gema_pkg;

   localparam int EMA_MAX   = 64;
   localparam int DIM_MAX   = 4096;
   localparam int DATA_W    = 16;
   localparam int CH_W      = 7;
   localparam int EMA_IDX_W = (EMA_MAX > 1) ? $clog2(EMA_MAX) : 1;
   localparam int POS_W     = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int CMP_W_A   = (POS_W > CH_W) ? POS_W : CH_W;
   localparam int CMP_W     = ((CMP_W_A > EMA_IDX_W) ? CMP_W_A : EMA_IDX_W) + 2;
   localparam int MUL_W     = 2 * (DATA_W + 1);
   localparam int ACC_W     = MUL_W + 2;

   localparam logic [CH_W-1:0] CH_RESET = CH_W'(16);

   // sigmoid breakpoints and offsets, |logit| in Q4.12
   localparam logic [16:0] SIG_BRK_LO  = 17'd4096;
   localparam logic [16:0] SIG_BRK_MID = 17'd9728;
   localparam logic [16:0] SIG_BRK_HI  = 17'd20480;
   localparam logic [16:0] SIG_OFS_LO  = 17'd32768;
   localparam logic [16:0] SIG_OFS_MID = 17'd40960;
   localparam logic [16:0] SIG_OFS_HI  = 17'd55296;
   localparam logic [16:0] SIG_ONE     = 17'd65536;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(32768);

   typedef struct packed {
      logic load;
      logic mul_f;
      logic mul_i;
      logic update;
      logic mul_g;
      logic emit;
   } gema_cmd_type;

   typedef struct packed {
      logic out_busy;
   } gema_status_type;

   // piecewise sigmoid, result unsigned Q0.16
   function automatic logic [DATA_W-1:0] sigmoid_q16(input logic signed [DATA_W-1:0] logit);
      logic [16:0] mag;
      logic [16:0] p;
      mag = logit[DATA_W-1] ? (17'd0 - {logit[DATA_W-1], logit}) : {1'b0, logit};
      if (mag < SIG_BRK_LO) begin
         p = SIG_OFS_LO + {mag[14:0], 2'b00};
      end else if (mag < SIG_BRK_MID) begin
         p = SIG_OFS_MID + {mag[15:0], 1'b0};
      end else if (mag < SIG_BRK_HI) begin
         p = SIG_OFS_HI + {1'b0, mag[16:1]};
      end else begin
         p = SIG_ONE;
      end
      if (!logit[DATA_W-1]) begin
         sigmoid_q16 = p[16] ? '1 : p[DATA_W-1:0];
      end else begin
         sigmoid_q16 = DATA_W'(SIG_ONE - p);
      end
   endfunction

   // round half up at bit 16, then clamp to signed 16 bits
   function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v + ROUND_HALF) >>> 16;
      if (r > SAT_MAX) begin
         round_sat = SAT_MAX[DATA_W-1:0];
      end else if (r < SAT_MIN) begin
         round_sat = SAT_MIN[DATA_W-1:0];
      end else begin
         round_sat = r[DATA_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/gema_channels_if.sv]
// ----------------------------------------------------------------------------
// gema channel interfaces
// Valid/ready channels for request items, result items and the csr write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gema_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_sample;
   logic signed [15:0] attn_sample;
   logic signed [15:0] forget_logit;
   logic signed [15:0] input_logit;
   logic signed [15:0] gate_logit;
   logic               last_element;

   modport source (output valid, x_sample, attn_sample, forget_logit, input_logit,
                   gate_logit, last_element, input ready);
   modport sink (input valid, x_sample, attn_sample, forget_logit, input_logit,
                 gate_logit, last_element, output ready);
endinterface

interface gema_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] fused_value;
   logic               out_last;

   modport source (output valid, fused_value, out_last, input ready);
   modport sink (input valid, fused_value, out_last, output ready);
endinterface

interface gema_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] ema_channels;

   modport source (output valid, ema_channels, input ready);
   modport sink (input valid, ema_channels, output ready);
endinterface

[hw/rtl/gated_ema_step.sv]
// A req transfer runs the steps mul_f, mul_i, update, mul_g and emit; rsp valid is registered at emit.
// A new request is taken only once the last one has emitted, set by the controller's step sequence
// around the single shared 17x17 multiplier and the ema store's registered read.
// A pending result holds in the output register; further stall holds the sequencer.
// Reset clears the ema store valid bits, position, gates and ema_channels (to 16).
// ----------------------------------------------------------------------------
// gated_ema_step
// Gated ema attention step: one vector element per request, one result each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gated_ema_step_macros.svh"

module gated_ema_step
   import gema_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gema_req_if.sink   req,
   gema_rsp_if.source rsp,
   gema_csr_if.sink   csr
);

   gema_cmd_type    cmd;
   gema_status_type status;
   logic            req_ready;

   gema_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gema_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .csr    (csr),
      .cmd    (cmd),
      .status (status)
   );

   assign req.ready = req_ready;

   `GEMA_ASSERT_NOW(a_one_step, clock, reset, 1'b1, $onehot0(cmd))
   `GEMA_ASSERT_NEXT(a_load_then_mul, clock, reset, cmd.load, cmd.mul_f && !req.ready)
   `GEMA_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, !status.out_busy)
   `GEMA_ASSERT_NOW(a_load_is_xfer, clock, reset, cmd.load, req.valid && req.ready)

endmodule

[hw/rtl/gema_ram.sv]
// ----------------------------------------------------------------------------
// gema_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gema_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gema_ctrl.sv]
// ----------------------------------------------------------------------------
// gema_ctrl
// Step sequencer: accepts one request, walks the datapath through its steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gema_ctrl
   import gema_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gema_status_type status,
   output gema_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_F,
      ST_MUL_I,
      ST_UPDATE,
      ST_MUL_G,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_F;
            end
         end
         ST_MUL_F: begin
            cmd.mul_f = 1'b1;
            state_in  = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_i = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MUL_G;
         end
         ST_MUL_G: begin
            cmd.mul_g = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the result
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

[hw/rtl/gema_dpath.sv]
// ----------------------------------------------------------------------------
// gema_dpath
// Gate latch, ema store, shared multiplier, rounding and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gema_dpath
   import gema_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   gema_req_if.sink        req,
   gema_rsp_if.source      rsp,
   gema_csr_if.sink        csr,
   input  gema_cmd_type    cmd,
   output gema_status_type status
);

   logic [CH_W-1:0]          ema_ch_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [DATA_W-1:0]        forget_g_ff;
   logic [DATA_W-1:0]        input_g_ff;
   logic [DATA_W-1:0]        output_g_ff;
   logic [EMA_MAX-1:0]       valid_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic signed [DATA_W-1:0] attn_ff;
   logic                     last_ff;
   logic                     in_ema_ff;
   logic                     st_valid_ff;
   logic [EMA_IDX_W-1:0]     idx_ff;
   logic signed [MUL_W-1:0]  p1_ff;
   logic signed [MUL_W-1:0]  p2_ff;
   logic signed [DATA_W-1:0] st_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic                     out_last_ff;
   logic                     rsp_valid_ff;

   logic [EMA_IDX_W-1:0]     rd_idx;
   logic                     in_ema;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] state_eff;
   logic signed [DATA_W:0]   mul_a;
   logic signed [DATA_W:0]   mul_b;
   logic signed [MUL_W-1:0]  mul_out;
   logic signed [DATA_W-1:0] st_new;
   logic                     ram_wr;

   assign rd_idx = EMA_IDX_W'(pos_ff);
   assign in_ema = (CMP_W'(pos_ff) < CMP_W'(ema_ch_ff)) && (CMP_W'(pos_ff) < CMP_W'(EMA_MAX));

   // an entry never written since reset reads as zero
   assign state_eff = st_valid_ff ? signed'(rd_data) : '0;

   // one shared multiplier, operands chosen by the current step
   always_comb begin
      mul_a = signed'({1'b0, output_g_ff});
      mul_b = signed'({attn_ff[DATA_W-1], attn_ff}) + signed'({st_ff[DATA_W-1], st_ff});
      if (cmd.mul_f) begin
         mul_a = signed'({1'b0, forget_g_ff});
         mul_b = signed'({state_eff[DATA_W-1], state_eff});
      end else if (cmd.mul_i) begin
         mul_a = signed'({1'b0, input_g_ff});
         mul_b = signed'({x_ff[DATA_W-1], x_ff});
      end
   end

   assign mul_out = mul_a * mul_b;
   assign st_new  = round_sat(ACC_W'(p1_ff) + ACC_W'(p2_ff));
   assign ram_wr  = cmd.update && in_ema_ff;

   gema_ram #(
      .WIDTH (DATA_W),
      .DEPTH (EMA_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (idx_ff),
      .wr_data (st_new),
      .rd_en   (cmd.load),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ema_ch_ff    <= CH_RESET;
         pos_ff       <= '0;
         forget_g_ff  <= '0;
         input_g_ff   <= '0;
         output_g_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            ema_ch_ff <= csr.ema_channels;
         end
         if (cmd.load && (pos_ff == '0)) begin
            forget_g_ff <= sigmoid_q16(req.forget_logit);
            input_g_ff  <= sigmoid_q16(req.input_logit);
            output_g_ff <= sigmoid_q16(req.gate_logit);
         end
         if (cmd.update) begin
            if (in_ema_ff) begin
               valid_ff[idx_ff] <= 1'b1;
            end
            // position saturates at the last slot until the vector ends
            if (last_ff) begin
               pos_ff <= '0;
            end else if (pos_ff != POS_W'(DIM_MAX - 1)) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff        <= req.x_sample;
         attn_ff     <= req.attn_sample;
         last_ff     <= req.last_element;
         in_ema_ff   <= in_ema;
         idx_ff      <= rd_idx;
         st_valid_ff <= valid_ff[rd_idx];
      end
      if (cmd.mul_f || cmd.mul_g) begin
         p1_ff <= mul_out;
      end
      if (cmd.mul_i) begin
         p2_ff <= mul_out;
      end
      if (cmd.update) begin
         st_ff <= in_ema_ff ? st_new : '0;
      end
      if (cmd.emit) begin
         out_value_ff <= round_sat(ACC_W'(p1_ff));
         out_last_ff  <= last_ff;
      end
   end

   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.fused_value = out_value_ff;
   assign rsp.out_last    = out_last_ff;
   assign status.out_busy = rsp_valid_ff && !rsp.ready;

endmodule
